/* rtl/kktl_pkg.sv */
// kktl_pkg: shared types and constants of the kth-largest tree edge block.
// No dependencies; all other files import it.
package kktl_pkg;

   localparam int END_BITS          = 10;
   localparam int FIELD_WEIGHT_BITS = 20;
   localparam int CSR_INDEX_BITS    = 8;
   localparam int CSR_DATA_BITS     = 11;
   localparam int RANK_BITS         = 4;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_BITS    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_NODE_COUNT        = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_COMPONENTS = 8'd1;

   localparam logic [CSR_DATA_BITS-1:0] NODE_COUNT_RESET = 11'd1024;
   localparam logic [CSR_DATA_BITS-1:0] TARGET_RESET     = 11'd1;
   localparam logic [RANK_BITS-1:0]     RANK_MAX         = 4'd15;

   typedef enum logic {
      ITEM_EDGE,
      ITEM_LAST
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [END_BITS-1:0]          end_a;
      logic [END_BITS-1:0]          end_b;
      logic [FIELD_WEIGHT_BITS-1:0] weight;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_PASS,
      ST_RUN,
      ST_FETCH,
      ST_MERGE,
      ST_KR_FETCH,
      ST_KR_EDGE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_JOIN,
      ST_RANK,
      ST_RES,
      ST_RES_WAIT,
      ST_OUT
   } state_type;

endpackage

/* rtl/kktl_req_if.sv */
// kktl_req_if: edge request channel.
// Depends on kktl_pkg.
interface kktl_req_if import kktl_pkg::*; ;
   logic                         valid;
   logic                         ready;
   logic [END_BITS-1:0]          end_a;
   logic [END_BITS-1:0]          end_b;
   logic [FIELD_WEIGHT_BITS-1:0] edge_weight;
   logic                         last_edge;

   modport source (output valid, end_a, end_b, edge_weight, last_edge, input ready);
   modport sink   (input valid, end_a, end_b, edge_weight, last_edge, output ready);
endinterface

/* rtl/kktl_rsp_if.sv */
// kktl_rsp_if: result channel.
// Depends on kktl_pkg.
interface kktl_rsp_if import kktl_pkg::*; ;
   logic                         valid;
   logic                         ready;
   logic [FIELD_WEIGHT_BITS-1:0] max_cost;
   logic                         edges_dropped;

   modport source (output valid, max_cost, edges_dropped, input ready);
   modport sink   (input valid, max_cost, edges_dropped, output ready);
endinterface

/* rtl/kktl_csr_if.sv */
// kktl_csr_if: register write channel.
// Depends on kktl_pkg.
interface kktl_csr_if import kktl_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/kktl_front.sv */
// kktl_front: accepts edge requests, classifies them and pushes them to the queue.
// Depends on kktl_pkg, kktl_req_if.
module kktl_front import kktl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   kktl_req_if.sink       req_ch,
   input  logic           queue_full,
   output logic           push,
   output queue_item_type push_item
);

   logic           valid_ff, valid_in;
   queue_item_type item_ff, item_in;

   assign push          = valid_ff && !queue_full;
   assign push_item     = item_ff;
   assign req_ch.ready  = !valid_ff || !queue_full;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         valid_in       = 1'b1;
         item_in.kind   = req_ch.last_edge ? ITEM_LAST : ITEM_EDGE;
         item_in.end_a  = req_ch.end_a;
         item_in.end_b  = req_ch.end_b;
         item_in.weight = req_ch.edge_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

/* rtl/kktl_queue.sv */
// kktl_queue: short request queue between front and back.
// Depends on kktl_pkg.
module kktl_queue import kktl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_item_type push_item,
   input  logic           pop,
   output logic           full,
   output queue_head_type head
);

   localparam int CNT_BITS = QUEUE_PTR_BITS + 1;

   queue_item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;

   assign full       = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/kktl_back.sv */
// kktl_back: edge store, merge sort, union-find Kruskal pass and result register.
// Depends on kktl_pkg, kktl_rsp_if.
module kktl_back import kktl_pkg::*; #(
   parameter int MAX_NODES   = 1024,
   parameter int MAX_EDGES   = 4096,
   parameter int WEIGHT_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  queue_head_type           head,
   output logic                     pop,
   input  logic [CSR_DATA_BITS-1:0] node_count,
   input  logic [CSR_DATA_BITS-1:0] target_components,
   kktl_rsp_if.source               rsp_ch
);

   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CW  = $clog2(MAX_EDGES + 1);
   localparam int SW  = CW + 2;
   localparam int NAW = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int KW  = WEIGHT_BITS + 2 * END_BITS;
   localparam int PW  = RANK_BITS + NAW;

   state_type state_ff, state_in;

   // stores
   logic [KW-1:0]          mem_a [MAX_EDGES];
   logic [KW-1:0]          mem_b [MAX_EDGES];
   logic [PW-1:0]          pmem  [MAX_NODES];
   logic [WEIGHT_BITS-1:0] tmem  [MAX_NODES];

   logic [KW-1:0]          ra0_ff, ra1_ff, rb0_ff, rb1_ff;
   logic [PW-1:0]          prd_ff;
   logic [WEIGHT_BITS-1:0] trd_ff;

   logic                   mem_a_we, mem_b_we, pm_we, tm_we;
   logic [EAW-1:0]         mem_a_waddr, mem_b_waddr, rd_addr0, rd_addr1;
   logic [KW-1:0]          mem_a_wdata, mem_b_wdata;
   logic [NAW-1:0]         pm_waddr, pm_raddr, tm_waddr, tm_raddr;
   logic [PW-1:0]          pm_wdata;
   logic [WEIGHT_BITS-1:0] tm_wdata;

   // control registers
   logic [CW-1:0]  loaded_ff, loaded_in;
   logic           ovf_ff, ovf_in;
   logic           src_ff, src_in;
   logic [NCW-1:0] n_ff, n_in, k_ff, k_in, clr_ff, clr_in, tcnt_ff, tcnt_in;
   logic [SW-1:0]  w_ff, w_in, lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [SW-1:0]  i_ff, i_in, j_ff, j_in, k_idx_ff, k_idx_in;
   logic [CW-1:0]  e_ff, e_in;
   logic [KW-1:0]  edge_ff, edge_in;
   logic [NAW-1:0] x_ff, x_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [RANK_BITS-1:0] rka_ff, rka_in, rkb_ff, rkb_in;
   logic           side_ff, side_in;
   logic [WEIGHT_BITS-1:0] cost_ff, cost_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WEIGHT_BITS-1:0] rsp_cost_ff, rsp_cost_in;
   logic                         rsp_drop_ff, rsp_drop_in;

   // shared decode
   logic [KW-1:0]          d0, d1, key_new;
   logic [31:0]            w32;
   logic                   full_store, take_i, take_j, pass_done, run_done;
   logic                   found, edge_out, res_zero, out_free, store_done;
   logic [SW-1:0]          lo_w, mid_c, mid_w, hi_c;
   logic [SW-1:0]          loaded_s;
   logic [END_BITS-1:0]    d0_a, d0_b;
   logic [NAW-1:0]         p_par;
   logic [RANK_BITS-1:0]   p_rank;
   logic [NCW-1:0]         n_clamp, k_clamp;
   logic [31:0]            cost32;

   assign d0       = src_ff ? rb0_ff : ra0_ff;
   assign d1       = src_ff ? rb1_ff : ra1_ff;
   assign w32      = 32'(head.item.weight);
   assign key_new  = {w32[WEIGHT_BITS-1:0], head.item.end_a, head.item.end_b};
   assign full_store = loaded_ff == CW'(MAX_EDGES);
   assign loaded_s = SW'(loaded_ff);

   assign take_i    = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (d0 <= d1));
   assign take_j    = !take_i && (j_ff < hi_ff);
   assign pass_done = w_ff >= loaded_s;
   assign run_done  = lo_ff >= loaded_s;
   assign lo_w      = lo_ff + w_ff;
   assign mid_c     = (lo_w < loaded_s) ? lo_w : loaded_s;
   assign mid_w     = mid_c + w_ff;
   assign hi_c      = (mid_w < loaded_s) ? mid_w : loaded_s;

   assign d0_a      = d0[2*END_BITS-1:END_BITS];
   assign d0_b      = d0[END_BITS-1:0];
   assign edge_out  = (32'(d0_a) >= 32'(n_ff)) || (32'(d0_b) >= 32'(n_ff));
   assign p_par     = prd_ff[NAW-1:0];
   assign p_rank    = prd_ff[NAW +: RANK_BITS];
   assign found     = p_par == x_ff;
   assign res_zero  = k_ff > tcnt_ff;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign store_done = e_ff >= loaded_ff;
   assign cost32    = 32'(cost_ff);

   always_comb begin
      if (node_count == '0) begin
         n_clamp = NCW'(1);
      end else if (32'(node_count) > MAX_NODES) begin
         n_clamp = NCW'(MAX_NODES);
      end else begin
         n_clamp = NCW'(node_count);
      end
      if (target_components == '0) begin
         k_clamp = NCW'(1);
      end else if (32'(target_components) > 32'(n_clamp)) begin
         k_clamp = n_clamp;
      end else begin
         k_clamp = NCW'(target_components);
      end
   end

   assign pop = (state_ff == ST_LOAD) && head.valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (head.valid && head.item.kind == ITEM_LAST) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (clr_ff + 1'b1 >= n_ff) begin
               state_in = ST_PASS;
            end
         end
         ST_PASS:     state_in = pass_done ? ST_KR_FETCH : ST_RUN;
         ST_RUN:      state_in = run_done ? ST_PASS : ST_FETCH;
         ST_FETCH:    state_in = ST_MERGE;
         ST_MERGE:    state_in = (take_i || take_j) ? ST_FETCH : ST_RUN;
         ST_KR_FETCH: state_in = store_done ? ST_RES : ST_KR_EDGE;
         ST_KR_EDGE:  state_in = edge_out ? ST_KR_FETCH : ST_FIND_RD;
         ST_FIND_RD:  state_in = ST_FIND_CHK;
         ST_FIND_CHK: state_in = (found && side_ff) ? ST_JOIN : ST_FIND_RD;
         ST_JOIN: begin
            if (ra_ff != rb_ff && rka_ff == rkb_ff && rka_ff != RANK_MAX) begin
               state_in = ST_RANK;
            end else begin
               state_in = ST_KR_FETCH;
            end
         end
         ST_RANK:     state_in = ST_KR_FETCH;
         ST_RES:      state_in = res_zero ? ST_OUT : ST_RES_WAIT;
         ST_RES_WAIT: state_in = ST_OUT;
         ST_OUT:      state_in = out_free ? ST_LOAD : ST_OUT;
         default:     state_in = ST_LOAD;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      loaded_in = loaded_ff;
      ovf_in    = ovf_ff;
      src_in    = src_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      clr_in    = clr_ff;
      tcnt_in   = tcnt_ff;
      w_in      = w_ff;
      lo_in     = lo_ff;
      mid_in    = mid_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_idx_in  = k_idx_ff;
      e_in      = e_ff;
      edge_in   = edge_ff;
      x_in      = x_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rka_in    = rka_ff;
      rkb_in    = rkb_ff;
      side_in   = side_ff;
      cost_in   = cost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_cost_in  = rsp_cost_ff;
      rsp_drop_in  = rsp_drop_ff;

      mem_a_we    = 1'b0;
      mem_b_we    = 1'b0;
      mem_a_waddr = EAW'(k_idx_ff);
      mem_b_waddr = EAW'(k_idx_ff);
      mem_a_wdata = take_i ? d0 : d1;
      mem_b_wdata = take_i ? d0 : d1;
      rd_addr0    = EAW'(i_ff);
      rd_addr1    = EAW'(j_ff);
      pm_we       = 1'b0;
      pm_waddr    = ra_ff;
      pm_wdata    = {rka_ff, rb_ff};
      pm_raddr    = x_ff;
      tm_we       = 1'b0;
      tm_waddr    = NAW'(tcnt_ff);
      tm_wdata    = edge_ff[KW-1:2*END_BITS];
      tm_raddr    = NAW'(tcnt_ff - k_ff);

      unique case (state_ff)
         ST_LOAD: begin
            src_in = 1'b0;
            if (head.valid) begin
               if (full_store) begin
                  ovf_in = 1'b1;
               end else begin
                  mem_a_we    = 1'b1;
                  mem_a_waddr = EAW'(loaded_ff);
                  mem_a_wdata = key_new;
                  loaded_in   = loaded_ff + 1'b1;
               end
               if (head.item.kind == ITEM_LAST) begin
                  n_in    = n_clamp;
                  k_in    = k_clamp;
                  clr_in  = '0;
                  tcnt_in = '0;
                  w_in    = SW'(1);
               end
            end
         end
         ST_CLEAR: begin
            pm_we    = 1'b1;
            pm_waddr = NAW'(clr_ff);
            pm_wdata = {{RANK_BITS{1'b0}}, NAW'(clr_ff)};
            clr_in   = clr_ff + 1'b1;
         end
         ST_PASS: begin
            lo_in = '0;
            e_in  = '0;
         end
         ST_RUN: begin
            if (run_done) begin
               w_in   = w_ff << 1;
               src_in = !src_ff;
            end else begin
               mid_in   = mid_c;
               hi_in    = hi_c;
               i_in     = lo_ff;
               j_in     = mid_c;
               k_idx_in = lo_ff;
            end
         end
         ST_FETCH: begin
         end
         ST_MERGE: begin
            if (take_i || take_j) begin
               mem_a_we = src_ff;
               mem_b_we = !src_ff;
               k_idx_in = k_idx_ff + 1'b1;
               if (take_i) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               lo_in = hi_ff;
            end
         end
         ST_KR_FETCH: begin
            rd_addr0 = EAW'(e_ff);
         end
         ST_KR_EDGE: begin
            edge_in = d0;
            x_in    = NAW'(d0_a);
            side_in = 1'b0;
            if (edge_out) begin
               e_in = e_ff + 1'b1;
            end
         end
         ST_FIND_RD: begin
         end
         ST_FIND_CHK: begin
            if (!found) begin
               x_in = p_par;
            end else if (!side_ff) begin
               ra_in   = x_ff;
               rka_in  = p_rank;
               x_in    = NAW'(edge_ff[END_BITS-1:0]);
               side_in = 1'b1;
            end else begin
               rb_in  = x_ff;
               rkb_in = p_rank;
            end
         end
         ST_JOIN: begin
            if (ra_ff == rb_ff) begin
               e_in = e_ff + 1'b1;
            end else begin
               pm_we   = 1'b1;
               tm_we   = 1'b1;
               tcnt_in = tcnt_ff + 1'b1;
               if (rka_ff < rkb_ff) begin
                  pm_waddr = ra_ff;
                  pm_wdata = {rka_ff, rb_ff};
               end else begin
                  pm_waddr = rb_ff;
                  pm_wdata = {rkb_ff, ra_ff};
               end
               if (!(rka_ff == rkb_ff && rka_ff != RANK_MAX)) begin
                  e_in = e_ff + 1'b1;
               end
            end
         end
         ST_RANK: begin
            pm_we    = 1'b1;
            pm_waddr = ra_ff;
            pm_wdata = {rka_ff + 1'b1, ra_ff};
            e_in     = e_ff + 1'b1;
         end
         ST_RES: begin
            cost_in = '0;
         end
         ST_RES_WAIT: begin
            cost_in = trd_ff;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = cost32[FIELD_WEIGHT_BITS-1:0];
               rsp_drop_in  = ovf_ff;
               loaded_in    = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         loaded_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      clr_ff      <= clr_in;
      tcnt_ff     <= tcnt_in;
      w_ff        <= w_in;
      lo_ff       <= lo_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_idx_ff    <= k_idx_in;
      e_ff        <= e_in;
      edge_ff     <= edge_in;
      x_ff        <= x_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rka_ff      <= rka_in;
      rkb_ff      <= rkb_in;
      side_ff     <= side_in;
      cost_ff     <= cost_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   always_ff @(posedge clock) begin
      if (mem_a_we) begin
         mem_a[mem_a_waddr] <= mem_a_wdata;
      end
      ra0_ff <= mem_a[rd_addr0];
      ra1_ff <= mem_a[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (mem_b_we) begin
         mem_b[mem_b_waddr] <= mem_b_wdata;
      end
      rb0_ff <= mem_b[rd_addr0];
      rb1_ff <= mem_b[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pmem[pm_waddr] <= pm_wdata;
      end
      prd_ff <= pmem[pm_raddr];
   end

   always_ff @(posedge clock) begin
      if (tm_we) begin
         tmem[tm_waddr] <= tm_wdata;
      end
      trd_ff <= tmem[tm_raddr];
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.max_cost      = rsp_cost_ff;
   assign rsp_ch.edges_dropped = rsp_drop_ff;

endmodule

/* rtl/kruskal_kth_largest_tree_edge.sv */
// kruskal_kth_largest_tree_edge: top level, register file and channel wiring.
// Depends on kktl_pkg, the kktl_*_if interfaces, kktl_front, kktl_queue, kktl_back.
//
// Edges are taken one request per cycle (unless the queue is full) into a four-entry
// queue and written to the edge store; the request with last_edge set closes the
// graph. Compute then runs: a parent-table clear of the clamped node_count entries,
// a merge sort of E stored edges over ceil(log2 E) passes (one store read pair per
// output edge), a Kruskal pass that fetches each edge, skips an edge with an endpoint
// out of range and otherwise runs its two finds and a join, and the result step.
// Requests queue up during compute until the queue fills. Edges past MAX_EDGES are
// dropped and flagged in the result.
module kruskal_kth_largest_tree_edge import kktl_pkg::*; #(
   parameter int MAX_NODES   = 1024,
   parameter int MAX_EDGES   = 4096,
   parameter int WEIGHT_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   kktl_req_if.sink    req_ch,
   kktl_rsp_if.source  rsp_ch,
   kktl_csr_if.sink    csr_ch
);

   logic [CSR_DATA_BITS-1:0] node_count_ff, node_count_in;
   logic [CSR_DATA_BITS-1:0] target_ff, target_in;
   logic                     queue_full, push, pop;
   queue_item_type           push_item;
   queue_head_type           head;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      node_count_in = node_count_ff;
      target_in     = target_ff;
      if (csr_ch.valid) begin
         if (csr_ch.index == REG_NODE_COUNT) begin
            node_count_in = csr_ch.data;
         end else if (csr_ch.index == REG_TARGET_COMPONENTS) begin
            target_in = csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         target_ff     <= TARGET_RESET;
      end else begin
         node_count_ff <= node_count_in;
         target_ff     <= target_in;
      end
   end

   kktl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   kktl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .head      (head)
   );

   kktl_back #(
      .MAX_NODES   (MAX_NODES),
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .node_count        (node_count_ff),
      .target_components (target_ff),
      .rsp_ch            (rsp_ch)
   );

endmodule
